>>> design/mdef_pkg.sv
// ----------------------------------------------------------------------------
// mdef_pkg
// Shared types, codes and sizes for the maze dead-end filler.
// ----------------------------------------------------------------------------
package mdef_pkg;

  // Default store size
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  // Field and counter widths
  localparam int COORD_W    = 6;   // cell row / column fields
  localparam int CNT_W      = 7;   // walker coordinates and grid sizes
  localparam int REMOVED_W  = 12;  // removed cell count
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // Register reset values
  localparam logic [CNT_W-1:0]   GRID_WIDTH_RST  = 7'd64;
  localparam logic [CNT_W-1:0]   GRID_HEIGHT_RST = 7'd64;
  localparam logic [COORD_W-1:0] START_ROW_RST   = 6'd0;
  localparam logic [COORD_W-1:0] START_COL_RST   = 6'd0;
  localparam logic [COORD_W-1:0] FINISH_ROW_RST  = 6'd63;
  localparam logic [COORD_W-1:0] FINISH_COL_RST  = 6'd63;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_ROW   = 3'd2,
    CFG_START_COL   = 3'd3,
    CFG_FINISH_ROW  = 3'd4,
    CFG_FINISH_COL  = 3'd5
  } cfg_idx_e;

  // Sweep order of a run
  typedef enum logic [1:0] {
    SWP_ROW_FWD = 2'd0,
    SWP_COL_FWD = 2'd1,
    SWP_ROW_REV = 2'd2,
    SWP_COL_REV = 2'd3
  } sweep_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CELL,
    S_RD_UP,
    S_RD_MID,
    S_RD_DN,
    S_EVAL,
    S_FIN
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic               cell_in;
  } item_t;

  typedef struct packed {
    logic                 cell_out;
    logic [REMOVED_W-1:0] removed_count;
  } result_t;

  // Walker control from the sequencer
  typedef struct packed {
    logic init;
    logic step;
  } walk_ctrl_t;

  // Walker position to the sequencer
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    sweep_e           sweep;
    logic             last;
  } walk_pos_t;

endpackage

>>> design/mdef_ram.sv
// ----------------------------------------------------------------------------
// mdef_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mdef_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/mdef_visit.sv
// ----------------------------------------------------------------------------
// mdef_visit
// Dead-end test for one cell: counts open neighbours over three stored rows.
// ----------------------------------------------------------------------------
module mdef_visit
  import mdef_pkg::*;
#(
  parameter int MaxCols = MAX_COLS_DEF
) (
  input  logic [MaxCols-1:0] up_i,
  input  logic [MaxCols-1:0] mid_i,
  input  logic [MaxCols-1:0] dn_i,
  input  logic [CNT_W-1:0]   row_i,
  input  logic [CNT_W-1:0]   col_i,
  input  logic [COORD_W-1:0] start_row_i,
  input  logic [COORD_W-1:0] start_col_i,
  input  logic [COORD_W-1:0] finish_row_i,
  input  logic [COORD_W-1:0] finish_col_i,
  output logic               fill_o,
  output logic [MaxCols-1:0] row_o
);

  localparam int ColAw = $clog2(MaxCols);

  logic [ColAw-1:0] c_idx;
  logic [ColAw-1:0] cl_idx;
  logic [ColAw-1:0] cr_idx;
  logic [2:0]       open_cnt;
  logic             is_start;
  logic             is_finish;

  // Column taps of the cell and its left and right neighbours
  assign c_idx  = ColAw'(col_i);
  assign cl_idx = ColAw'(col_i - 7'd1);
  assign cr_idx = ColAw'(col_i + 7'd1);

  // Count open neighbours
  assign open_cnt = 3'(!mid_i[cl_idx]) + 3'(!mid_i[cr_idx])
                  + 3'(!up_i[c_idx])   + 3'(!dn_i[c_idx]);

  assign is_start  = (row_i == CNT_W'(start_row_i))  && (col_i == CNT_W'(start_col_i));
  assign is_finish = (row_i == CNT_W'(finish_row_i)) && (col_i == CNT_W'(finish_col_i));

  // Fill an open dead end that is neither start nor finish
  assign fill_o = !mid_i[c_idx] && !is_start && !is_finish && (open_cnt < 3'd2);

  always_comb begin
    row_o        = mid_i;
    row_o[c_idx] = 1'b1;
  end

endmodule

>>> design/mdef_walk.sv
// ----------------------------------------------------------------------------
// mdef_walk
// Cell walker: steps through the interior cells in the four sweep orders.
// ----------------------------------------------------------------------------
module mdef_walk
  import mdef_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  walk_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0] width_i,
  input  logic [CNT_W-1:0] height_i,
  output walk_pos_t        pos_o
);

  logic [CNT_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] col_q, col_d;
  sweep_e           sweep_q, sweep_d;
  logic [CNT_W-1:0] wm2;
  logic [CNT_W-1:0] hm2;
  logic             last;

  assign wm2 = width_i - 7'd2;
  assign hm2 = height_i - 7'd2;

  // End of the current sweep
  always_comb begin
    unique case (sweep_q)
      SWP_ROW_FWD: last = (row_q == hm2) && (col_q == wm2);
      SWP_COL_FWD: last = (col_q == wm2) && (row_q == hm2);
      SWP_ROW_REV: last = (row_q == hm2) && (col_q == 7'd1);
      SWP_COL_REV: last = (col_q == wm2) && (row_q == 7'd1);
    endcase
  end

  // Advance the position
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    sweep_d = sweep_q;
    if (ctrl_i.init) begin
      row_d   = 7'd1;
      col_d   = 7'd1;
      sweep_d = SWP_ROW_FWD;
    end else if (ctrl_i.step && last) begin
      unique case (sweep_q)
        SWP_ROW_FWD: begin
          sweep_d = SWP_COL_FWD;
          row_d   = 7'd1;
          col_d   = 7'd1;
        end
        SWP_COL_FWD: begin
          sweep_d = SWP_ROW_REV;
          row_d   = 7'd1;
          col_d   = wm2;
        end
        SWP_ROW_REV: begin
          sweep_d = SWP_COL_REV;
          row_d   = hm2;
          col_d   = 7'd1;
        end
        SWP_COL_REV: begin
          sweep_d = SWP_ROW_FWD;
          row_d   = 7'd1;
          col_d   = 7'd1;
        end
      endcase
    end else if (ctrl_i.step) begin
      unique case (sweep_q)
        SWP_ROW_FWD: begin
          if (col_q == wm2) begin
            col_d = 7'd1;
            row_d = row_q + 7'd1;
          end else begin
            col_d = col_q + 7'd1;
          end
        end
        SWP_COL_FWD: begin
          if (row_q == hm2) begin
            row_d = 7'd1;
            col_d = col_q + 7'd1;
          end else begin
            row_d = row_q + 7'd1;
          end
        end
        SWP_ROW_REV: begin
          if (col_q == 7'd1) begin
            col_d = wm2;
            row_d = row_q + 7'd1;
          end else begin
            col_d = col_q - 7'd1;
          end
        end
        SWP_COL_REV: begin
          if (row_q == 7'd1) begin
            row_d = hm2;
            col_d = col_q + 7'd1;
          end else begin
            row_d = row_q - 7'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= 7'd1;
      col_q   <= 7'd1;
      sweep_q <= SWP_ROW_FWD;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      sweep_q <= sweep_d;
    end
  end

  assign pos_o.row   = row_q;
  assign pos_o.col   = col_q;
  assign pos_o.sweep = sweep_q;
  assign pos_o.last  = last;

endmodule

>>> design/maze_dead_end_filler.sv
// ----------------------------------------------------------------------------
// maze_dead_end_filler
// Maze grid store with cell write/read and in-place dead-end filling.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// item      in         start_i && !busy_o      item_i   (item_t)
// result    out        done_o, one cycle       result_o (result_t)
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Write and read items pass through S_CELL to S_FIN; other codes and cells
// outside the store go straight to S_FIN. A run visits each interior cell in
// S_RD_UP, S_RD_MID, S_RD_DN and S_EVAL, since the single RAM read port
// fetches three rows per visit. It stops after the first sweep if that fills
// nothing, else after four sweeps; under 3 rows or columns it visits none.
// The grid RAM is not cleared by reset; config registers reset to defaults.
// done_o cannot be stalled; busy_o stays high until the done cycle ends.
// ----------------------------------------------------------------------------
module maze_dead_end_filler
  import mdef_pkg::*;
#(
  parameter int MaxRows = MAX_ROWS_DEF,
  parameter int MaxCols = MAX_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  item_t                 item_i,
  output logic                  done_o,
  output result_t               result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int RowAw = $clog2(MaxRows);
  localparam int ColAw = $clog2(MaxCols);

  state_e state_q, state_d;

  // Configuration registers
  logic [CNT_W-1:0]   grid_width_q;
  logic [CNT_W-1:0]   grid_height_q;
  logic [COORD_W-1:0] start_row_q;
  logic [COORD_W-1:0] start_col_q;
  logic [COORD_W-1:0] finish_row_q;
  logic [COORD_W-1:0] finish_col_q;

  // Datapath registers
  item_t                item_q, item_d;
  logic [MaxCols-1:0]   up_q, up_d;
  logic [MaxCols-1:0]   mid_q, mid_d;
  logic [REMOVED_W-1:0] total_q, total_d;
  result_t              res_q, res_d;

  logic [CNT_W-1:0]   eff_w;
  logic [CNT_W-1:0]   eff_h;
  logic               tiny;
  logic               in_range;
  logic               ram_we;
  logic [RowAw-1:0]   ram_waddr;
  logic [MaxCols-1:0] ram_wdata;
  logic [RowAw-1:0]   ram_raddr;
  logic [MaxCols-1:0] ram_rdata;
  logic [MaxCols-1:0] cell_row_wr;
  logic               fill;
  logic [MaxCols-1:0] fill_row;
  logic               run_end;
  walk_ctrl_t         walk_ctrl;
  walk_pos_t          walk_pos;

  // Clip grid size to the store
  assign eff_w = (int'(grid_width_q) > MaxCols) ? CNT_W'(MaxCols) : grid_width_q;
  assign eff_h = (int'(grid_height_q) > MaxRows) ? CNT_W'(MaxRows) : grid_height_q;
  assign tiny  = (eff_w < 7'd3) || (eff_h < 7'd3);

  assign in_range = (int'(item_i.cell_row) < MaxRows) && (int'(item_i.cell_col) < MaxCols);

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      start_row_q   <= START_ROW_RST;
      start_col_q   <= START_COL_RST;
      finish_row_q  <= FINISH_ROW_RST;
      finish_col_q  <= FINISH_COL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        CFG_START_ROW:   start_row_q   <= cfg_data_i[COORD_W-1:0];
        CFG_START_COL:   start_col_q   <= cfg_data_i[COORD_W-1:0];
        CFG_FINISH_ROW:  finish_row_q  <= cfg_data_i[COORD_W-1:0];
        CFG_FINISH_COL:  finish_col_q  <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Grid store, one row per word
  mdef_ram #(
    .Width (MaxCols),
    .Depth (MaxRows)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mdef_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (walk_ctrl),
    .width_i  (eff_w),
    .height_i (eff_h),
    .pos_o    (walk_pos)
  );

  mdef_visit #(
    .MaxCols (MaxCols)
  ) u_visit (
    .up_i         (up_q),
    .mid_i        (mid_q),
    .dn_i         (ram_rdata),
    .row_i        (walk_pos.row),
    .col_i        (walk_pos.col),
    .start_row_i  (start_row_q),
    .start_col_i  (start_col_q),
    .finish_row_i (finish_row_q),
    .finish_col_i (finish_col_q),
    .fill_o       (fill),
    .row_o        (fill_row)
  );

  // Single-cell update of the fetched row
  always_comb begin
    cell_row_wr = ram_rdata;
    cell_row_wr[ColAw'(item_q.cell_col)] = item_q.cell_in;
  end

  assign total_d = (state_q == S_EVAL) ? (total_q + REMOVED_W'(fill)) :
                   (state_q == S_IDLE) ? '0 : total_q;

  // Stop after the last sweep, or after a first sweep that fills nothing
  assign run_end = walk_pos.last &&
                   ((walk_pos.sweep == SWP_COL_REV) ||
                    ((walk_pos.sweep == SWP_ROW_FWD) && (total_d == '0)));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (item_i.func) inside
            FUNC_WRITE, FUNC_READ: state_d = in_range ? S_CELL : S_FIN;
            FUNC_RUN:              state_d = tiny ? S_FIN : S_RD_UP;
            default:               state_d = S_FIN;
          endcase
        end
      end
      S_CELL:   state_d = S_FIN;
      S_RD_UP:  state_d = S_RD_MID;
      S_RD_MID: state_d = S_RD_DN;
      S_RD_DN:  state_d = S_EVAL;
      S_EVAL:   state_d = run_end ? S_FIN : S_RD_UP;
      S_FIN:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = RowAw'(walk_pos.row);
    ram_wdata      = fill_row;
    ram_raddr      = RowAw'(item_q.cell_row);
    walk_ctrl.init = 1'b0;
    walk_ctrl.step = 1'b0;
    item_d         = item_q;
    up_d           = up_q;
    mid_d          = mid_q;
    res_d          = res_q;
    unique case (state_q)
      S_IDLE: begin
        item_d         = item_i;
        res_d          = '0;
        ram_raddr      = RowAw'(item_i.cell_row);
        walk_ctrl.init = start_i;
      end
      S_CELL: begin
        if (item_q.func == FUNC_WRITE) begin
          ram_we    = 1'b1;
          ram_waddr = RowAw'(item_q.cell_row);
          ram_wdata = cell_row_wr;
        end else begin
          res_d.cell_out = ram_rdata[ColAw'(item_q.cell_col)];
        end
      end
      S_RD_UP: begin
        ram_raddr = RowAw'(walk_pos.row - 7'd1);
      end
      S_RD_MID: begin
        ram_raddr = RowAw'(walk_pos.row);
        up_d      = ram_rdata;
      end
      S_RD_DN: begin
        ram_raddr = RowAw'(walk_pos.row + 7'd1);
        mid_d     = ram_rdata;
      end
      S_EVAL: begin
        ram_we              = fill;
        walk_ctrl.step      = 1'b1;
        res_d.removed_count = total_d;
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    up_q   <= up_d;
    mid_q  <= mid_d;
    res_q  <= res_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_FIN);
  assign result_o = res_q;

  // Checks
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done without busy");

  a_done_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("busy held after done");

  a_we_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> busy_o)
    else $error("grid write while idle");

  a_one_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.cell_out && (result_o.removed_count != '0)))
    else $error("both result fields set");

  a_interior : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> ((walk_pos.row != '0) && (walk_pos.col != '0)))
    else $error("visit on border cell");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the maze dead-end filler. Writes mazes cell by cell,
// runs dead-end filling and reads cells back. A local model of the grid and
// the registers predicts every result. A checker compares each strobed result
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import mdef_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 40;

  // Codes the package leaves unnamed
  localparam logic [1:0]           FUNC_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  item_t                 item_i      = '0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  busy_o;
  logic                  done_o;
  result_t               result_o;
  logic                  cfg_ready_o;

  // Local copy of the maze store and the registers
  bit [MAX_COLS_DEF-1:0] grid_model  [MAX_ROWS_DEF];
  bit [MAX_COLS_DEF-1:0] written_map [MAX_ROWS_DEF];
  logic [CNT_W-1:0]      cols_in_use = GRID_WIDTH_RST;
  logic [CNT_W-1:0]      rows_in_use = GRID_HEIGHT_RST;
  logic [COORD_W-1:0]    start_r     = START_ROW_RST;
  logic [COORD_W-1:0]    start_c     = START_COL_RST;
  logic [COORD_W-1:0]    finish_r    = FINISH_ROW_RST;
  logic [COORD_W-1:0]    finish_c    = FINISH_COL_RST;

  result_t expected_results [$];
  int      errors      = 0;
  int      items_sent  = 0;
  int      idle_pct    = 0;
  int      cycle_count = 0;

  maze_dead_end_filler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model --

  function automatic bit wall_at(int r, int c);
    if (r < 0 || c < 0 || r >= MAX_ROWS_DEF || c >= MAX_COLS_DEF) return 1'b0;
    return grid_model[r][c];
  endfunction

  // Wall off one swept cell if it is an open dead end; return 1 if filled
  function automatic int try_fill(int r, int c);
    int open_cnt;
    if (wall_at(r, c)) return 0;
    if (r == int'(start_r) && c == int'(start_c)) return 0;
    if (r == int'(finish_r) && c == int'(finish_c)) return 0;
    open_cnt = int'(!wall_at(r, c - 1)) + int'(!wall_at(r, c + 1))
             + int'(!wall_at(r + 1, c)) + int'(!wall_at(r - 1, c));
    if (open_cnt >= 2) return 0;
    grid_model[r][c] = 1'b1;
    return 1;
  endfunction

  // Four in-place sweeps over the interior; stop early if the first fills none
  function automatic int fill_dead_ends();
    int w, h, total;
    w = (cols_in_use > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_in_use);
    h = (rows_in_use > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_in_use);
    total = 0;
    if (w < 3 || h < 3) return 0;
    for (int a = 1; a < h - 1; a++)
      for (int b = 1; b < w - 1; b++) total += try_fill(a, b);
    if (total == 0) return 0;
    for (int a = 1; a < w - 1; a++)
      for (int b = 1; b < h - 1; b++) total += try_fill(b, a);
    for (int a = 1; a < h - 1; a++)
      for (int b = 1; b < w - 1; b++) total += try_fill(a, (w - 1) - b);
    for (int a = 1; a < w - 1; a++)
      for (int b = 1; b < h - 1; b++) total += try_fill((h - 1) - b, a);
    return total;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t res;
    res = '0;
    case (it.func)
      FUNC_WRITE: begin
        grid_model[it.cell_row][it.cell_col]  = it.cell_in;
        written_map[it.cell_row][it.cell_col] = 1'b1;
      end
      FUNC_RUN:  res.removed_count = REMOVED_W'(fill_dead_ends());
      FUNC_READ: res.cell_out = grid_model[it.cell_row][it.cell_col];
      default: ;
    endcase
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GRID_WIDTH:  cols_in_use = data;
      CFG_GRID_HEIGHT: rows_in_use = data;
      CFG_START_ROW:   start_r     = data[COORD_W-1:0];
      CFG_START_COL:   start_c     = data[COORD_W-1:0];
      CFG_FINISH_ROW:  finish_r    = data[COORD_W-1:0];
      CFG_FINISH_COL:  finish_c    = data[COORD_W-1:0];
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------- drivers --

  function automatic item_t make_item(func_e f, int r, int c, bit v);
    item_t it;
    it.func     = f;
    it.cell_row = COORD_W'(r);
    it.cell_col = COORD_W'(c);
    it.cell_in  = v;
    return it;
  endfunction

  // Coordinate register value: mostly inside the interior, bit 6 random
  function automatic logic [CFG_DATA_W-1:0] pick_coord(int n);
    int v;
    if (n >= 3 && $urandom_range(0, 9) < 7) v = $urandom_range(1, n - 2);
    else v = $urandom_range(0, 63);
    return {1'($urandom_range(0, 1)), 6'(v)};
  endfunction

  // Idle at random, then hold start until the transfer
  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    expected_results.insert(expected_results.size(), predict_result(it));
    items_sent++;
  endtask

  task automatic drop_start();
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  // Hold off until every result is back and the block is idle
  task automatic wait_idle();
    drop_start();
    while (expected_results.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ------------------------------------------------------------- checker --

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result strobed with no item pending");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result_o.cell_out !== want.cell_out) begin
          $error("cell_out: expected %0d, got %0d", want.cell_out, result_o.cell_out);
          errors++;
        end
        if (result_o.removed_count !== want.removed_count) begin
          $error("removed_count: expected %0d, got %0d",
                 want.removed_count, result_o.removed_count);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------- tests --

  // Corner cells of the store, both values, and the unused code
  task automatic test_cell_access();
    send_item(make_item(FUNC_WRITE, 0, 0, 1'b1));
    send_item(make_item(FUNC_WRITE, 63, 63, 1'b0));
    send_item(make_item(FUNC_READ, 0, 0, 1'b0));
    send_item(make_item(FUNC_READ, 63, 63, 1'b1));
    send_item(make_item(func_e'(FUNC_UNUSED), 63, 63, 1'b1));
  endtask

  // Grids under three rows or columns have no interior
  task automatic test_tiny_grid();
    wait_idle();
    write_reg(CFG_GRID_WIDTH, 7'd2);
    write_reg(CFG_GRID_HEIGHT, 7'd64);
    send_item(make_item(FUNC_RUN, 0, 0, 1'b0));
    wait_idle();
    write_reg(CFG_GRID_WIDTH, 7'd3);
    write_reg(CFG_GRID_HEIGHT, 7'd1);
    send_item(make_item(FUNC_RUN, 0, 0, 1'b0));
  endtask

  // 3x3 maze: open grid fills nothing, start cell is protected, then one fill
  task automatic test_small_maze();
    wait_idle();
    write_reg(CFG_GRID_WIDTH, 7'd3);
    write_reg(CFG_GRID_HEIGHT, 7'd3);
    write_reg(CFG_START_ROW, 7'h40);
    write_reg(CFG_START_COL, 7'h40);
    write_reg(CFG_FINISH_ROW, 7'h7F);
    write_reg(CFG_FINISH_COL, 7'h7F);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) send_item(make_item(FUNC_WRITE, r, c, 1'b0));
    send_item(make_item(FUNC_RUN, 0, 0, 1'b0));
    wait_idle();
    write_reg(CFG_START_ROW, 7'd1);
    write_reg(CFG_START_COL, 7'd1);
    send_item(make_item(FUNC_WRITE, 2, 1, 1'b1));
    send_item(make_item(FUNC_WRITE, 1, 0, 1'b1));
    send_item(make_item(FUNC_WRITE, 1, 2, 1'b1));
    send_item(make_item(FUNC_RUN, 0, 0, 1'b0));
    wait_idle();
    write_reg(CFG_START_ROW, 7'd0);
    write_reg(CFG_START_COL, 7'd0);
    send_item(make_item(FUNC_RUN, 0, 0, 1'b0));
    send_item(make_item(FUNC_READ, 1, 1, 1'b0));
  endtask

  // Writes to indexes past the last register change nothing
  task automatic test_unused_registers();
    wait_idle();
    write_reg(CFG_UNUSED_LO, 7'h7F);
    write_reg(CFG_UNUSED_HI, 7'h2A);
    send_item(make_item(FUNC_RUN, 63, 63, 1'b1));
  endtask

  // One random maze: configure, write every used cell, then mixed traffic
  task automatic run_maze_phase(int phase);
    int  kind, w_data, h_data, w, h, density, n_ops, op, r, c;
    bit  border_wall, v;
    case (phase % 4)
      0:       idle_pct = 0;
      1:       idle_pct = 55;
      2:       idle_pct = 0;
      default: idle_pct = 33;
    endcase
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      w_data = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
      h_data = $urandom_range(3, 4);
    end else if (kind < 4) begin
      w_data = $urandom_range(3, 4);
      h_data = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
    end else if (kind == 4) begin
      w_data = $urandom_range(0, 2);
      h_data = $urandom_range(0, 12);
      if ($urandom_range(0, 1)) begin
        r      = w_data;
        w_data = h_data;
        h_data = r;
      end
    end else begin
      w_data = $urandom_range(3, 10);
      h_data = $urandom_range(3, 10);
    end
    w = (w_data > MAX_COLS_DEF) ? MAX_COLS_DEF : w_data;
    h = (h_data > MAX_ROWS_DEF) ? MAX_ROWS_DEF : h_data;

    wait_idle();
    write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w_data));
    write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h_data));
    write_reg(CFG_START_ROW, pick_coord(h));
    write_reg(CFG_START_COL, pick_coord(w));
    write_reg(CFG_FINISH_ROW, pick_coord(h));
    write_reg(CFG_FINISH_COL, pick_coord(w));

    // Fill the used area: walled border most of the time, random interior
    density     = $urandom_range(10, 60);
    border_wall = ($urandom_range(0, 4) != 0);
    for (r = 0; r < h; r++)
      for (c = 0; c < w; c++) begin
        if (border_wall && (r == 0 || c == 0 || r == h - 1 || c == w - 1)) v = 1'b1;
        else v = ($urandom_range(0, 99) < density);
        send_item(make_item(FUNC_WRITE, r, c, v));
      end
    send_item(make_item(FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 1)));

    n_ops = $urandom_range(4, 16);
    for (int k = 0; k < n_ops; k++) begin
      op = $urandom_range(0, 19);
      if (op < 8) begin
        // Read only cells that hold a written value
        if (w > 0 && h > 0 && $urandom_range(0, 1)) begin
          r = $urandom_range(0, h - 1);
          c = $urandom_range(0, w - 1);
        end else begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
        end
        if (!written_map[r][c]) begin
          r = 0;
          c = 0;
        end
        send_item(make_item(FUNC_READ, r, c, $urandom_range(0, 1)));
      end else if (op < 13 && w > 0 && h > 0) begin
        send_item(make_item(FUNC_WRITE, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                            $urandom_range(0, 1)));
      end else if (op < 15) begin
        send_item(make_item(FUNC_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 1)));
      end else if (op < 18) begin
        send_item(make_item(FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 1)));
      end else if (op == 18) begin
        send_item(make_item(func_e'(FUNC_UNUSED), $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 1)));
      end else begin
        // Pause the sender until every result is back
        drop_start();
        while (expected_results.size() != 0) @(posedge clk_i);
      end
    end
    send_item(make_item(FUNC_RUN, 0, 0, 1'b0));
  endtask

  task automatic test_random_mazes();
    int base, phase;
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      run_maze_phase(phase);
      phase++;
    end
    idle_pct = 0;
  endtask

  // ------------------------------------------------------------ sequence --

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_seq
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cell_access();
    test_tiny_grid();
    test_small_maze();
    test_unused_registers();
    test_random_mazes();

    // Drain outstanding results, then watch for strays
    drop_start();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/mdef_pkg.sv
design/mdef_ram.sv
design/mdef_visit.sv
design/mdef_walk.sv
design/maze_dead_end_filler.sv
bench/tb_top.sv
